// ===== sv/lsd_pkg.sv =====
// lsd_pkg: shared types, constants and helper functions for the lsb stego deframer
// depends on nothing; used by the interfaces, front, back and top level

package lsd_pkg;

    // decoder phases
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    // result status codes
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    // signature symbols and repeat count
    localparam logic [2:0] SYM_HEAD    = 3'b111;
    localparam logic [2:0] SYM_MID     = 3'b101;
    localparam logic [2:0] SYM_TAIL    = 3'b010;
    localparam logic [1:0] SIG_REPEATS = 2'd3;

    // region register and pixel counter limits
    localparam int          REGION_W     = 25;
    localparam logic [24:0] REGION_RESET = 25'h100_0000;
    localparam logic [24:0] CNT_SAT      = 25'h100_0000;

    // field widths of one result word
    localparam int PART_LEN_W = 10;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified pixel word handed from front to back
    typedef struct packed {
        logic       restart;
        logic [2:0] sym;
    } t_pix_word;

    // one result word
    typedef struct packed {
        logic                  part_index;
        logic [2:0]            payload_bits;
        logic [PART_LEN_W-1:0] part_length;
        logic                  last;
        logic [1:0]            status;
    } t_result;

    // remainder by three of a 4-bit value
    function automatic logic [1:0] mod3(input logic [3:0] v);
        logic [1:0] m;
        case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11, 4'd14:       m = 2'd2;
            default:                              m = 2'd0;
        endcase
        return m;
    endfunction

    // bits to add so that a value with this remainder becomes a multiple of three
    function automatic logic [1:0] pad3(input logic [1:0] m);
        logic [1:0] p;
        case (m)
            2'd1:    p = 2'd2;
            2'd2:    p = 2'd1;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/lsd_if.sv =====
// lsd_if: valid/ready channel interfaces for pixel words and result words
// depends on lsd_pkg for the result field widths

interface lsd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       region_start;

    modport source (output valid, output red, output green, output blue,
                    output region_start, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input region_start, output ready);
endinterface

interface lsd_res_if;
    logic                          valid;
    logic                          ready;
    logic                          part_index;
    logic [2:0]                    payload_bits;
    logic [lsd_pkg::PART_LEN_W-1:0] part_length;
    logic                          last;
    logic [1:0]                    status;

    modport source (output valid, output part_index, output payload_bits,
                    output part_length, output last, output status, input ready);
    modport sink   (input valid, input part_index, input payload_bits,
                    input part_length, input last, input status, output ready);
endinterface

// ===== sv/lsd_front.sv =====
// lsd_front: accepts pixel words, forms the lsb symbol and queues it for the decoder
// depends on lsd_pkg (t_pix_word, QUEUE_DEPTH)

module lsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic                i_region_start,
    output logic                o_word_valid,
    input  logic                i_word_ready,
    output lsd_pkg::t_pix_word  o_word
);
    localparam int PTR_W = $clog2(lsd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lsd_pkg::QUEUE_DEPTH + 1);

    lsd_pkg::t_pix_word r_mem [lsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    lsd_pkg::t_pix_word in_word;
    logic               push, pop;

    // symbol from the channel lsbs, red as msb
    always_comb begin
        in_word.restart = i_region_start;
        in_word.sym     = {i_red[0], i_green[0], i_blue[0]};
    end

    assign o_ready      = (r_count != CNT_W'(lsd_pkg::QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_word_valid = (r_count != '0);
    assign pop          = o_word_valid && i_word_ready;
    assign o_word       = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(lsd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(lsd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_word;
        end
    end

endmodule

// ===== sv/lsd_back.sv =====
// lsd_back: signature search, length capture and payload emission, one word per cycle unless the result side stalls
// depends on lsd_pkg (t_phase, t_pix_word, t_result, codes and helpers)

module lsd_back #(
    parameter int LENGTH_BITS = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [lsd_pkg::REGION_W-1:0]        i_region_pixels,
    input  logic                                i_word_valid,
    output logic                                o_word_ready,
    input  lsd_pkg::t_pix_word                  i_word,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output lsd_pkg::t_result                    o_res
);
    localparam int LEN_PIXELS = (LENGTH_BITS + 2) / 3;
    localparam int FIRST_BITS = LENGTH_BITS - 3 * (LEN_PIXELS - 1);
    localparam logic [2:0] FIRST_MASK = 3'((1 << FIRST_BITS) - 1);
    localparam int SEEN_W = $clog2(LEN_PIXELS + 1);
    localparam int PAD_W  = LENGTH_BITS + 1;

    lsd_pkg::t_phase              r_phase, n_phase, c_phase;
    logic [1:0]                   r_step, n_step, c_step;
    logic [1:0]                   r_rep, n_rep, c_rep;
    logic [LENGTH_BITS-1:0]       r_len, n_len, c_len;
    logic [SEEN_W-1:0]            r_seen, n_seen, c_seen;
    logic [1:0]                   r_mod, n_mod, c_mod;
    logic [PAD_W-1:0]             r_padded, n_padded, c_padded;
    logic [PAD_W-1:0]             r_rem, n_rem, c_rem;
    logic                         r_part, n_part, c_part;
    logic [lsd_pkg::REGION_W-1:0] r_cnt, n_cnt, c_cnt;
    logic                         r_out_valid, n_out_valid;
    lsd_pkg::t_result             r_out, n_out;

    logic                         step;
    logic [2:0]                   sym;
    logic [2:0]                   sym_m;
    logic [LENGTH_BITS+2:0]       len_wide;
    logic [LENGTH_BITS-1:0]       len_new;
    logic [1:0]                   mod_new;
    logic [PAD_W-1:0]             padded_new;
    logic [1:0]                   rep_inc;

    // take a word whenever the output register is free or being emptied
    assign step         = i_word_valid && (!r_out_valid || i_res_ready);
    assign o_word_ready = step;
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;
    assign sym          = i_word.sym;

    // state seen by this word, after an optional region restart
    always_comb begin
        c_phase  = i_word.restart ? lsd_pkg::PH_SEARCH : r_phase;
        c_step   = i_word.restart ? 2'd0 : r_step;
        c_rep    = i_word.restart ? 2'd0 : r_rep;
        c_len    = i_word.restart ? '0 : r_len;
        c_seen   = i_word.restart ? '0 : r_seen;
        c_mod    = i_word.restart ? 2'd0 : r_mod;
        c_padded = i_word.restart ? '0 : r_padded;
        c_rem    = i_word.restart ? '0 : r_rem;
        c_part   = i_word.restart ? 1'b0 : r_part;
        c_cnt    = i_word.restart ? lsd_pkg::REGION_W'(1) : r_cnt;
    end

    // length field arithmetic; remainder by three tracked one symbol at a time
    always_comb begin
        sym_m      = (c_seen == '0) ? (sym & FIRST_MASK) : sym;
        len_wide   = {c_len, sym};
        len_new    = len_wide[LENGTH_BITS-1:0];
        mod_new    = lsd_pkg::mod3(4'({(c_seen == '0) ? 2'd0 : c_mod, 1'b0}) + 4'(sym_m));
        padded_new = PAD_W'(len_new) + PAD_W'(lsd_pkg::pad3(mod_new));
        rep_inc    = c_rep + 2'd1;
    end

    // next state and result word
    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_rep       = r_rep;
        n_len       = r_len;
        n_seen      = r_seen;
        n_mod       = r_mod;
        n_padded    = r_padded;
        n_rem       = r_rem;
        n_part      = r_part;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;

        if (step) begin
            n_phase  = c_phase;
            n_step   = c_step;
            n_rep    = c_rep;
            n_len    = c_len;
            n_seen   = c_seen;
            n_mod    = c_mod;
            n_padded = c_padded;
            n_rem    = c_rem;
            n_part   = c_part;
            n_cnt    = c_cnt;

            if (c_phase != lsd_pkg::PH_DONE) begin
                if (c_cnt >= i_region_pixels) begin
                    // region limit reached while decoding
                    n_out_valid        = 1'b1;
                    n_out.part_index   = c_part;
                    n_out.payload_bits = 3'd0;
                    n_out.part_length  = (c_phase == lsd_pkg::PH_PAYLOAD) ?
                                         lsd_pkg::PART_LEN_W'(c_padded) : '0;
                    n_out.last         = 1'b1;
                    n_out.status       = lsd_pkg::ST_TRUNCATED;
                    n_phase            = lsd_pkg::PH_DONE;
                end else begin
                    if (c_cnt != lsd_pkg::CNT_SAT) begin
                        n_cnt = c_cnt + 1'b1;
                    end
                    case (c_phase)
                        lsd_pkg::PH_SEARCH: begin
                            // signature triple matcher
                            if (sym == lsd_pkg::SYM_HEAD) begin
                                n_step = 2'd1;
                            end else if (sym == lsd_pkg::SYM_MID && c_step == 2'd1) begin
                                n_step = 2'd2;
                            end else if (sym == lsd_pkg::SYM_TAIL && c_step == 2'd2) begin
                                n_step = 2'd0;
                                n_rep  = rep_inc;
                            end else begin
                                n_step = 2'd0;
                                n_rep  = 2'd0;
                            end
                            if (sym == lsd_pkg::SYM_TAIL && c_step == 2'd2 &&
                                rep_inc == lsd_pkg::SIG_REPEATS) begin
                                n_step  = 2'd0;
                                n_rep   = 2'd0;
                                n_phase = lsd_pkg::PH_LENGTH;
                                n_len   = '0;
                                n_seen  = '0;
                            end
                        end
                        lsd_pkg::PH_LENGTH: begin
                            n_len  = len_new;
                            n_mod  = mod_new;
                            n_seen = c_seen + 1'b1;
                            if (c_seen == SEEN_W'(LEN_PIXELS - 1)) begin
                                n_seen   = '0;
                                n_mod    = 2'd0;
                                n_padded = padded_new;
                                n_rem    = padded_new;
                                if (len_new == '0) begin
                                    // empty part
                                    n_out_valid        = 1'b1;
                                    n_out.part_index   = c_part;
                                    n_out.payload_bits = 3'd0;
                                    n_out.part_length  = '0;
                                    n_out.last         = 1'b1;
                                    n_out.status       = lsd_pkg::ST_EMPTY;
                                    if (!c_part) begin
                                        n_part   = 1'b1;
                                        n_phase  = lsd_pkg::PH_LENGTH;
                                        n_len    = '0;
                                        n_padded = '0;
                                        n_rem    = '0;
                                    end else begin
                                        n_phase = lsd_pkg::PH_DONE;
                                    end
                                end else begin
                                    n_phase = lsd_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        lsd_pkg::PH_PAYLOAD: begin
                            // one symbol per payload pixel
                            n_rem              = c_rem - PAD_W'(3);
                            n_out_valid        = 1'b1;
                            n_out.part_index   = c_part;
                            n_out.payload_bits = sym;
                            n_out.part_length  = lsd_pkg::PART_LEN_W'(c_padded);
                            n_out.last         = (c_rem == PAD_W'(3));
                            n_out.status       = lsd_pkg::ST_DATA;
                            if (c_rem == PAD_W'(3)) begin
                                if (!c_part) begin
                                    n_part   = 1'b1;
                                    n_phase  = lsd_pkg::PH_LENGTH;
                                    n_len    = '0;
                                    n_seen   = '0;
                                    n_mod    = 2'd0;
                                    n_padded = '0;
                                    n_rem    = '0;
                                end else begin
                                    n_phase = lsd_pkg::PH_DONE;
                                end
                            end
                        end
                        default: begin
                            n_phase = c_phase;
                        end
                    endcase
                end
            end
        end
    end

    // decoder state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lsd_pkg::PH_SEARCH;
            r_step      <= 2'd0;
            r_rep       <= 2'd0;
            r_len       <= '0;
            r_seen      <= '0;
            r_mod       <= 2'd0;
            r_padded    <= '0;
            r_rem       <= '0;
            r_part      <= 1'b0;
            r_cnt       <= lsd_pkg::REGION_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_rep       <= n_rep;
            r_len       <= n_len;
            r_seen      <= n_seen;
            r_mod       <= n_mod;
            r_padded    <= n_padded;
            r_rem       <= n_rem;
            r_part      <= n_part;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== sv/lsb_stego_deframer_top.sv =====
// lsb_stego_deframer_top: region register plus front queue and back decoder
// depends on lsd_pkg, lsd_pix_if, lsd_res_if, lsd_front and lsd_back
//
// Takes one RGB pixel word per cycle and forms a 3-bit symbol from the channel
// lsbs (red as msb). It hunts for three repeats of the triple 111,101,010, then
// reads two parts, each a LENGTH_BITS-bit length (padded up to a multiple of
// three) followed by one payload pixel per 3-bit result word. region_start on a
// pixel restarts decoding with that pixel as pixel 0. Reaching the region limit
// gives one word with truncated status. Sustained rate is one pixel per cycle
// with at most one result word per pixel; a pixel's result word is registered: the
// pixel is first stored in the two-entry front queue, and the decoder writes the
// output register as the pixel leaves the queue. Both sides may stall on their
// own: the queue absorbs input while the output register holds a word not yet
// taken.
// Write region_pixels only while no pixel is in flight.

module lsb_stego_deframer_top #(
    parameter int LENGTH_BITS = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lsd_pkg::REGION_W-1:0] i_cfg_data,
    lsd_pix_if.sink                      i_pix,
    lsd_res_if.source                    o_res
);
    logic [lsd_pkg::REGION_W-1:0] r_region;
    logic                         word_valid;
    logic                         word_ready;
    lsd_pkg::t_pix_word           word;
    lsd_pkg::t_result             res;

    // region size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= lsd_pkg::REGION_RESET;
        end else if (i_cfg_we) begin
            r_region <= i_cfg_data;
        end
    end

    // pixel intake and queue
    lsd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_pix.valid),
        .o_ready        (i_pix.ready),
        .i_red          (i_pix.red),
        .i_green        (i_pix.green),
        .i_blue         (i_pix.blue),
        .i_region_start (i_pix.region_start),
        .o_word_valid   (word_valid),
        .i_word_ready   (word_ready),
        .o_word         (word)
    );

    // decoder and output register
    lsd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_region_pixels (r_region),
        .i_word_valid    (word_valid),
        .o_word_ready    (word_ready),
        .i_word          (word),
        .o_res_valid     (o_res.valid),
        .i_res_ready     (o_res.ready),
        .o_res           (res)
    );

    // result word onto the channel
    assign o_res.part_index   = res.part_index;
    assign o_res.payload_bits = res.payload_bits;
    assign o_res.part_length  = res.part_length;
    assign o_res.last         = res.last;
    assign o_res.status       = res.status;

endmodule

// ===== tb/sv/tb_lsb_stego_deframer_top.sv =====
`timescale 1ns / 1ps
// tb_lsb_stego_deframer_top: self-checking bench for the lsb stego deframer top level
// depends on lsd_pkg, lsd_pix_if, lsd_res_if and lsb_stego_deframer_top

module tb_lsb_stego_deframer_top;

    localparam int LEN_BITS      = 9;
    localparam int LEN_PIXELS    = (LEN_BITS + 2) / 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_PIXELS  = 28;
    localparam int NUM_PHASES    = 10;
    localparam logic [lsd_pkg::REGION_W-1:0] REGION_MIN = 25'd1;
    localparam logic [lsd_pkg::REGION_W-1:0] REGION_MAX = 25'h100_0000;

    // one row of the directed stimulus table
    typedef enum logic {ROW_PIXEL, ROW_REGION} t_row_kind;
    typedef struct packed {
        t_row_kind                    kind;
        logic [lsd_pkg::REGION_W-1:0] region;
        logic [2:0]                   sym;
        logic [7:0]                   fill;
        logic                         start;
        logic                         typed;
        logic                         has_word;
        lsd_pkg::t_result             word;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [lsd_pkg::REGION_W-1:0] i_cfg_data;

    lsd_pix_if pix_if();
    lsd_res_if res_if();

    lsb_stego_deframer_top #(
        .LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    // decoder state mirrored by the predictor
    logic [lsd_pkg::REGION_W-1:0]   region_limit;
    lsd_pkg::t_phase                dec_phase;
    logic [23:0]                    pix_count;
    logic [1:0]                     sig_step;
    logic [1:0]                     sig_reps;
    logic [LEN_BITS-1:0]            len_acc;
    int                             len_seen;
    logic [7:0]                     payload_left;
    logic                           cur_part;
    logic [lsd_pkg::PART_LEN_W-1:0] padded_len;

    lsd_pkg::t_result decoded_words[$];
    t_row             dir_rows[$];

    bit no_idle;
    int err_count;
    int pixels_decoded;
    int pixels_sent;
    int words_checked;
    int regions_written;
    int cycle_count;
    int big_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter with a hard limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles", $time, cycle_count);
        $display("Verification failed");
        $finish;
    end

    function automatic void restart_decoder();
        pix_count    = '0;
        dec_phase    = lsd_pkg::PH_SEARCH;
        sig_step     = '0;
        sig_reps     = '0;
        len_acc      = '0;
        len_seen     = 0;
        payload_left = '0;
        cur_part     = 1'b0;
        padded_len   = '0;
    endfunction

    // move on to the second part, or finish after it
    function automatic void next_part();
        if (cur_part == 1'b0) begin
            cur_part     = 1'b1;
            dec_phase    = lsd_pkg::PH_LENGTH;
            len_acc      = '0;
            len_seen     = 0;
            padded_len   = '0;
            payload_left = '0;
        end else begin
            dec_phase = lsd_pkg::PH_DONE;
        end
    endfunction

    // one pixel into the decoder; returns 1 when it yields a result word
    function automatic bit decode_pixel(input logic [2:0] sym, input logic start,
                                        output lsd_pkg::t_result word);
        int unsigned acc;
        word = '0;
        if (start) restart_decoder();
        if (dec_phase == lsd_pkg::PH_DONE) return 1'b0;
        pixels_decoded++;

        // region limit: stop with a truncated word
        if ({2'b00, pix_count} + 26'd1 >= {1'b0, region_limit}) begin
            word.part_index  = cur_part;
            word.part_length = (dec_phase == lsd_pkg::PH_PAYLOAD) ? padded_len : '0;
            word.last        = 1'b1;
            word.status      = lsd_pkg::ST_TRUNCATED;
            dec_phase        = lsd_pkg::PH_DONE;
            return 1'b1;
        end
        if (pix_count != 24'hFF_FFFF) pix_count++;

        case (dec_phase)
            // hunt for three back-to-back signature triples
            lsd_pkg::PH_SEARCH: begin
                if (sym == lsd_pkg::SYM_HEAD) begin
                    sig_step = 2'd1;
                end else if (sym == lsd_pkg::SYM_MID && sig_step == 2'd1) begin
                    sig_step = 2'd2;
                end else if (sym == lsd_pkg::SYM_TAIL && sig_step == 2'd2) begin
                    sig_step = 2'd0;
                    sig_reps++;
                end else begin
                    sig_step = 2'd0;
                    sig_reps = 2'd0;
                end
                if (sig_reps >= lsd_pkg::SIG_REPEATS) begin
                    sig_reps  = 2'd0;
                    sig_step  = 2'd0;
                    dec_phase = lsd_pkg::PH_LENGTH;
                    len_acc   = '0;
                    len_seen  = 0;
                end
                return 1'b0;
            end
            // length field, msb first, padded to a multiple of three
            lsd_pkg::PH_LENGTH: begin
                len_acc = LEN_BITS'({len_acc, sym});
                len_seen++;
                if (len_seen < LEN_PIXELS) return 1'b0;
                acc          = 32'(len_acc);
                acc          = acc + (3 - acc % 3) % 3;
                padded_len   = lsd_pkg::PART_LEN_W'(acc);
                payload_left = 8'(acc / 3);
                len_seen     = 0;
                if (acc == 0) begin
                    word.part_index = cur_part;
                    word.last       = 1'b1;
                    word.status     = lsd_pkg::ST_EMPTY;
                    next_part();
                    return 1'b1;
                end
                dec_phase = lsd_pkg::PH_PAYLOAD;
                return 1'b0;
            end
            // payload: one symbol per word
            default: begin
                payload_left--;
                word.part_index   = cur_part;
                word.payload_bits = sym;
                word.part_length  = padded_len;
                word.last         = (payload_left == 8'd0);
                word.status       = lsd_pkg::ST_DATA;
                if (payload_left == 8'd0) next_part();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [2:0] signature_symbol(input int pos);
        case (pos % 3)
            0:       return lsd_pkg::SYM_HEAD;
            1:       return lsd_pkg::SYM_MID;
            default: return lsd_pkg::SYM_TAIL;
        endcase
    endfunction

    function automatic lsd_pkg::t_result mk_word(input logic part, input logic [2:0] bits,
                                        input logic [lsd_pkg::PART_LEN_W-1:0] len,
                                        input logic last, input logic [1:0] status);
        lsd_pkg::t_result w;
        w.part_index   = part;
        w.payload_bits = bits;
        w.part_length  = len;
        w.last         = last;
        w.status       = status;
        return w;
    endfunction

    function automatic void add_pixel(input logic [2:0] sym, input logic [7:0] fill,
                                      input logic start, input logic typed,
                                      input logic has_word, input lsd_pkg::t_result word);
        t_row r;
        r          = '0;
        r.kind     = ROW_PIXEL;
        r.sym      = sym;
        r.fill     = fill;
        r.start    = start;
        r.typed    = typed;
        r.has_word = has_word;
        r.word     = word;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_region(input logic [lsd_pkg::REGION_W-1:0] value);
        t_row r;
        r        = '0;
        r.kind   = ROW_REGION;
        r.region = value;
        dir_rows.push_back(r);
    endfunction

    // drive one pixel word; the expectation is queued once it is taken
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic start,
                              input logic typed, input logic has_word,
                              input lsd_pkg::t_result word);
        int               gap;
        bit               produced;
        lsd_pkg::t_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid        <= 1'b1;
        pix_if.red          <= red;
        pix_if.green        <= green;
        pix_if.blue         <= blue;
        pix_if.region_start <= start;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
        produced = decode_pixel({red[0], green[0], blue[0]}, start, predicted);
        if (typed) begin
            if (has_word) decoded_words.push_back(word);
        end else if (produced) begin
            decoded_words.push_back(predicted);
        end
    endtask

    // pixel with the given symbol and random upper bits
    task automatic send_sym(input logic [2:0] sym, input logic start);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r    = 8'($urandom_range(0, 255));
        g    = 8'($urandom_range(0, 255));
        b    = 8'($urandom_range(0, 255));
        r[0] = sym[2];
        g[0] = sym[1];
        b[0] = sym[0];
        send_pixel(r, g, b, start, 1'b0, 1'b0, '0);
    endtask

    // hold the sender until every expected word is back, then let the block settle
    task automatic drain_words();
        int waited;
        pix_if.valid <= 1'b0;
        waited = 0;
        while (decoded_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (decoded_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, decoded_words.size());
            err_count++;
            decoded_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_region(input logic [lsd_pkg::REGION_W-1:0] value);
        drain_words();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        region_limit = value;
        regions_written++;
    endtask

    // one random frame: mostly well formed, some broken, some loose noise
    task automatic send_frame();
        int         kind;
        int         n;
        int         i;
        int         bad_pos;
        int         part;
        int         sel;
        int         len_v;
        logic [2:0] s;
        logic       first;
        kind  = $urandom_range(0, 9);
        first = 1'b1;
        if (kind == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) send_sym(3'($urandom_range(0, 7)), $urandom_range(0, 7) == 0);
            return;
        end

        // junk ahead of the signature
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        for (i = 0; i < n; i++) begin
            send_sym(3'($urandom_range(0, 7)), first);
            first = 1'b0;
        end

        // signature, one symbol spoiled in broken frames
        bad_pos = (kind == 1) ? $urandom_range(0, 8) : -1;
        for (i = 0; i < 9; i++) begin
            s = signature_symbol(i);
            if (i == bad_pos) s = 3'($urandom_range(0, 7));
            send_sym(s, first);
            first = 1'b0;
        end

        // two parts: length field then payload
        for (part = 0; part < 2; part++) begin
            sel = $urandom_range(0, 19);
            if (sel < 3) begin
                len_v = 0;
            end else if (sel == 3 && big_left > 0 && region_limit > 25'd600) begin
                len_v = $urandom_range(0, 1) ? (1 << LEN_BITS) - 1
                                             : $urandom_range((1 << LEN_BITS) - 12,
                                                              (1 << LEN_BITS) - 2);
                big_left--;
            end else begin
                len_v = $urandom_range(1, 30);
            end
            for (i = LEN_PIXELS - 1; i >= 0; i--) send_sym(3'(len_v >> (3 * i)), 1'b0);
            repeat ((len_v + 2) / 3)
                send_sym(3'($urandom_range(0, 7)), kind == 2 && $urandom_range(0, 15) == 0);
        end
        repeat ($urandom_range(0, 2)) send_sym(3'($urandom_range(0, 7)), 1'b0);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            err_count++;
        end
    endtask

    // result side: random stalls, every taken word checked against the oldest expectation
    initial begin : result_sink
        int               gap;
        lsd_pkg::t_result got;
        lsd_pkg::t_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
            got.part_index   = res_if.part_index;
            got.payload_bits = res_if.payload_bits;
            got.part_length  = res_if.part_length;
            got.last         = res_if.last;
            got.status       = res_if.status;
            words_checked++;
            if (decoded_words.size() == 0) begin
                $display("%0t: unexpected word part %0d bits %0d length %0d last %0d status %0d",
                         $time, got.part_index, got.payload_bits, got.part_length,
                         got.last, got.status);
                err_count++;
            end else begin
                want = decoded_words.pop_front();
                cmp_field("part_index", 16'(want.part_index), 16'(got.part_index));
                cmp_field("payload_bits", 16'(want.payload_bits), 16'(got.payload_bits));
                cmp_field("part_length", 16'(want.part_length), 16'(got.part_length));
                cmp_field("last", 16'(want.last), 16'(got.last));
                cmp_field("status", 16'(want.status), 16'(got.status));
            end
        end
    end

    // stimulus: reset, directed table, then random phases over several region sizes
    initial begin : stimulus
        t_row                         row;
        int                           i;
        int                           phase_idx;
        int                           phase_start;
        logic [lsd_pkg::REGION_W-1:0] setting;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        pix_if.valid        <= 1'b0;
        pix_if.red          <= '0;
        pix_if.green        <= '0;
        pix_if.blue         <= '0;
        pix_if.region_start <= 1'b0;
        res_if.ready        <= 1'b0;
        no_idle         = 1'b0;
        err_count       = 0;
        pixels_decoded  = 0;
        pixels_sent     = 0;
        words_checked   = 0;
        regions_written = 0;
        big_left        = 4;
        region_limit    = lsd_pkg::REGION_RESET;
        restart_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-pixel region: truncates at once, then stays finished
        add_region(REGION_MIN);
        add_pixel(lsd_pkg::SYM_HEAD, 8'hFF, 1'b1, 1'b1, 1'b1,
                  mk_word(1'b0, 3'd0, '0, 1'b1, lsd_pkg::ST_TRUNCATED));
        add_pixel(3'd0, 8'h00, 1'b0, 1'b1, 1'b0, '0);
        // broken triple and a repeated head before a full signature
        add_region(REGION_MAX);
        add_pixel(lsd_pkg::SYM_HEAD, 8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_pixel(lsd_pkg::SYM_MID, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(3'd3, 8'hAA, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(lsd_pkg::SYM_HEAD, 8'h55, 1'b0, 1'b0, 1'b0, '0);
        for (i = 0; i < 9; i++)
            add_pixel(signature_symbol(i), (i % 2) ? 8'hAA : 8'h55, 1'b0, 1'b0, 1'b0, '0);
        // first part has zero length
        add_pixel(3'd0, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(3'd0, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(3'd0, 8'hAA, 1'b0, 1'b1, 1'b1,
                  mk_word(1'b0, 3'd0, '0, 1'b1, lsd_pkg::ST_EMPTY));
        // second part: length one, padded to three bits
        add_pixel(3'd0, 8'h55, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(3'd0, 8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(3'd1, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_pixel(3'd6, 8'hAA, 1'b0, 1'b1, 1'b1,
                  mk_word(1'b1, 3'd6, 10'd3, 1'b1, lsd_pkg::ST_DATA));
        // both parts done: pixel ignored
        add_pixel(lsd_pkg::SYM_HEAD, 8'hFF, 1'b0, 1'b1, 1'b0, '0);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_REGION)
                write_region(row.region);
            else
                send_pixel({row.fill[7:1], row.sym[2]}, {row.fill[7:1], row.sym[1]},
                           {row.fill[7:1], row.sym[0]}, row.start, row.typed,
                           row.has_word, row.word);
        end

        // random phases
        for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
            case (phase_idx)
                0:       setting = REGION_MAX;
                1:       setting = REGION_MIN;
                2:       setting = 25'd2;
                3:       setting = 25'd14;
                4:       setting = 25'd25;
                5:       setting = 25'd60;
                6:       setting = 25'($urandom_range(3, 400));
                7:       setting = REGION_MAX - 25'd1;
                8:       setting = 25'($urandom_range(700, 1 << 24));
                default: setting = 25'd120;
            endcase
            write_region(setting);
            no_idle     = (phase_idx % 3 == 1);
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS) send_frame();
        end
        no_idle = 1'b0;
        drain_words();

        $display("run covered %0d pixels sent, %0d decoded, %0d result words, %0d region settings",
                 pixels_sent, pixels_decoded, words_checked, regions_written);
        $display("search, empty and long parts, restarts and truncation took %0d cycles",
                 cycle_count);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== lsb_stego_deframer_top.f =====
sv/lsd_pkg.sv
sv/lsd_if.sv
sv/lsd_front.sv
sv/lsd_back.sv
sv/lsb_stego_deframer_top.sv
tb/sv/tb_lsb_stego_deframer_top.sv
